// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define ESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ESC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `ESC_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ESC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  localparam int CHAR_BITS = 8;
  localparam int TABLE_W   = 64;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_TABLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR  = 3'd4;

  localparam logic [CHAR_BITS-1:0] ESCAPE_RESET = 8'd92;

  // output queue
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = 2;
  localparam int OBUF_CNT_W = 3;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_out;
    logic                 char_valid;
    logic                 end_of_output;
    logic                 last_of_run;
  } res_t;

endpackage

// File: sv/esc_ifs.sv
`timescale 1ns / 1ps

interface esc_in_if;
  logic                            valid;
  logic                            ready;
  logic [esc_pkg::CHAR_BITS-1:0]   char_in;
  logic                            end_of_input;
  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface esc_out_if;
  logic                            valid;
  logic                            ready;
  logic [esc_pkg::CHAR_BITS-1:0]   char_out;
  logic                            char_valid;
  logic                            end_of_output;
  logic                            last_of_run;
  modport source (output valid, output char_out, output char_valid,
                  output end_of_output, output last_of_run, input ready);
  modport sink (input valid, input char_out, input char_valid,
                input end_of_output, input last_of_run, output ready);
endinterface

interface esc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [esc_pkg::CFG_IDX_W-1:0]   index;
  logic [esc_pkg::TABLE_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/esc_lookup.sv
`timescale 1ns / 1ps

module esc_lookup #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic [esc_pkg::TABLE_W-1:0]   key_table_i,
  input  logic [esc_pkg::TABLE_W-1:0]   pair_table_i,
  input  logic [esc_pkg::COUNT_W-1:0]   count_i,
  input  logic [esc_pkg::CHAR_BITS-1:0] key_i,
  output logic                          hit_o,
  output logic [esc_pkg::CHAR_BITS-1:0] pair_o
);

  // scan from the top so the lowest matching entry wins
  always_comb begin
    hit_o  = 1'b0;
    pair_o = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((esc_pkg::COUNT_W'(i) < count_i) &&
          (key_table_i[i*esc_pkg::CHAR_BITS +: esc_pkg::CHAR_BITS] == key_i)) begin
        hit_o  = 1'b1;
        pair_o = pair_table_i[i*esc_pkg::CHAR_BITS +: esc_pkg::CHAR_BITS];
      end
    end
  end

endmodule

// File: sv/esc_fifo.sv
`timescale 1ns / 1ps

module esc_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       push_n_i,
  input  esc_pkg::res_t                    wdata0_i,
  input  esc_pkg::res_t                    wdata1_i,
  output logic [esc_pkg::OBUF_CNT_W-1:0]   count_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output esc_pkg::res_t                    rdata_o
);

  esc_pkg::res_t                       mem_q [esc_pkg::OBUF_DEPTH];
  logic [esc_pkg::OBUF_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [esc_pkg::OBUF_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [esc_pkg::OBUF_CNT_W-1:0]      count_q, count_d;
  logic                                pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  assign wr_ptr_d = wr_ptr_q + esc_pkg::OBUF_PTR_W'(push_n_i);
  assign rd_ptr_d = rd_ptr_q + esc_pkg::OBUF_PTR_W'(pop);
  assign count_d  = count_q + esc_pkg::OBUF_CNT_W'(push_n_i) - esc_pkg::OBUF_CNT_W'(pop);

  // up to two beats written per cycle
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_q + esc_pkg::OBUF_PTR_W'(1)] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: sv/escape_sequence_codec.sv
`timescale 1ns / 1ps
// Table-driven escape codec on a character stream.
// in_i carries one character per beat with an end-of-string flag; out_o
// carries result beats (character, character-valid, end-of-string,
// last-of-run). cfg_i writes the mode, entry count, symbol and code tables
// and the escape character; write it only while the codec is idle.
// A character accepted on in_i passes through the input register and
// then the output queue, whose head drives the result beats on out_o.
// Throughput: one input beat per cycle while each character yields one
// result and the receiver does not stall; an encoded special character
// yields two beats, so the single output port then limits the input rate.
// The input register advances only while the 4-entry output queue has room
// for two beats, so a stalled receiver backs up into in_i.ready without
// losing or repeating beats.
// Reset clears the escape-pending flag, the pipeline and the queue, and
// loads encode mode, zero entries, zero tables and backslash as escape.

module escape_sequence_codec #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  esc_cfg_if.sink  cfg_i,
  esc_in_if.sink   in_i,
  esc_out_if.source out_o
);

  // configuration
  logic                            decode_mode_q;
  logic [esc_pkg::COUNT_W-1:0]     entry_count_q;
  logic [esc_pkg::TABLE_W-1:0]     symbol_table_q;
  logic [esc_pkg::TABLE_W-1:0]     code_table_q;
  logic [esc_pkg::CHAR_BITS-1:0]   escape_char_q;

  // input register
  logic                            s1_valid_q;
  logic [esc_pkg::CHAR_BITS-1:0]   s1_char_q;
  logic                            s1_eoi_q;
  logic                            s1_adv;
  logic                            in_take;

  logic                            pending_q, pending_d;

  logic                            sym_hit, code_hit;
  logic [esc_pkg::CHAR_BITS-1:0]   sym_pair, code_pair;

  esc_pkg::res_t                   res0, res1, rdata;
  logic [1:0]                      res_n;
  logic [1:0]                      push_n;
  logic [esc_pkg::OBUF_CNT_W-1:0]  obuf_count;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q  <= 1'b0;
      entry_count_q  <= '0;
      symbol_table_q <= '0;
      code_table_q   <= '0;
      escape_char_q  <= esc_pkg::ESCAPE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        esc_pkg::CFG_DECODE_MODE:  decode_mode_q  <= cfg_i.data[0];
        esc_pkg::CFG_ENTRY_COUNT:  entry_count_q  <= cfg_i.data[esc_pkg::COUNT_W-1:0];
        esc_pkg::CFG_SYMBOL_TABLE: symbol_table_q <= cfg_i.data;
        esc_pkg::CFG_CODE_TABLE:   code_table_q   <= cfg_i.data;
        esc_pkg::CFG_ESCAPE_CHAR:  escape_char_q  <= cfg_i.data[esc_pkg::CHAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // room for the worst case of two beats
  assign s1_adv     = s1_valid_q &&
                      (obuf_count <= esc_pkg::OBUF_CNT_W'(esc_pkg::OBUF_DEPTH - 2));
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pending_q  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        pending_q <= pending_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= in_i.char_in;
      s1_eoi_q  <= in_i.end_of_input;
    end
  end

  esc_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_sym_lookup (
    .key_table_i (symbol_table_q),
    .pair_table_i(code_table_q),
    .count_i     (entry_count_q),
    .key_i       (s1_char_q),
    .hit_o       (sym_hit),
    .pair_o      (code_pair)
  );

  esc_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_code_lookup (
    .key_table_i (code_table_q),
    .pair_table_i(symbol_table_q),
    .count_i     (entry_count_q),
    .key_i       (s1_char_q),
    .hit_o       (code_hit),
    .pair_o      (sym_pair)
  );

  always_comb begin
    res0      = '{char_out: s1_char_q, char_valid: 1'b1,
                  end_of_output: 1'b0, last_of_run: 1'b0};
    res1      = res0;
    res_n     = 2'd1;
    pending_d = pending_q;
    if (!decode_mode_q) begin
      pending_d = 1'b0;
      if (sym_hit) begin
        res0.char_out = escape_char_q;
        res1.char_out = code_pair;
        res_n         = 2'd2;
      end
    end else if (pending_q) begin
      pending_d = 1'b0;
      if (code_hit) begin
        res0.char_out = sym_pair;
      end
    end else if (s1_char_q == escape_char_q) begin
      pending_d = 1'b1;
      res_n     = 2'd0;
    end
    if (s1_eoi_q) begin
      pending_d = 1'b0;
      // dropped escape at end of string leaves a bare end marker
      if (res_n == 2'd0) begin
        res_n           = 2'd1;
        res0.char_out   = '0;
        res0.char_valid = 1'b0;
      end
      if (res_n == 2'd2) begin
        res1.end_of_output = 1'b1;
      end else begin
        res0.end_of_output = 1'b1;
      end
    end
    if (res_n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else if (res_n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
  end

  assign push_n = s1_adv ? res_n : 2'd0;

  esc_fifo u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(push_n),
    .wdata0_i(res0),
    .wdata1_i(res1),
    .count_o (obuf_count),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rdata_o (rdata)
  );

  assign out_o.char_out      = rdata.char_out;
  assign out_o.char_valid    = rdata.char_valid;
  assign out_o.end_of_output = rdata.end_of_output;
  assign out_o.last_of_run   = rdata.last_of_run;

endmodule

// File: sv/esc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [esc_pkg::CHAR_BITS-1:0]   char_out,
  input logic                            char_valid,
  input logic                            end_of_output,
  input logic                            last_of_run
);

  `ESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped while stalled")
  `ESC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(char_out) && $stable(char_valid) && $stable(end_of_output) && $stable(last_of_run), "out payload changed while stalled")
  // a bare marker only closes a string
  `ESC_ASSERT_IMPL(a_bare_marker, out_valid && !char_valid, end_of_output && last_of_run && (char_out == '0), "bare marker without end flags")
  `ESC_ASSERT_IMPL(a_end_closes_run, out_valid && end_of_output, last_of_run, "end of string inside a run")

endmodule

bind escape_sequence_codec esc_checker u_esc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .char_out     (out_o.char_out),
  .char_valid   (out_o.char_valid),
  .end_of_output(out_o.end_of_output),
  .last_of_run  (out_o.last_of_run)
);
